@@ hdl/tql_pkg.sv @@
// ----------------------------------------------------------------------------
// tql_pkg: shared types, constants and index helpers
// Table geometry, register indexes, ALU operation codes and index reduction.
// ----------------------------------------------------------------------------
package tql_pkg;

	localparam int NUM_STATES  = 256;
	localparam int NUM_ACTIONS = 8;
	localparam int DEPTH       = NUM_STATES * NUM_ACTIONS;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int ST_W        = $clog2(NUM_STATES);
	localparam int ACT_W       = $clog2(NUM_ACTIONS);

	localparam int ST_RECIP  = (65536 + NUM_STATES - 1) / NUM_STATES;
	localparam int ACT_RECIP = (65536 + NUM_ACTIONS - 1) / NUM_ACTIONS;

	localparam logic [16:0] ONE_Q16       = 17'd65536;
	localparam logic [16:0] LR_RESET      = 17'd6554;
	localparam logic [16:0] DISCOUNT_RESET = 17'd58982;

	localparam logic REG_LEARNING_RATE = 1'b0;
	localparam logic REG_DISCOUNT      = 1'b1;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic [16:0]        f;
	} alu_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} mem_wr_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
		logic signed [31:0] r;
		if (x > 34'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -34'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic [ST_W-1:0] state_mod(input logic [7:0] x);
		logic [31:0] q;
		logic [31:0] r;
		q = (32'(x) * 32'(ST_RECIP)) >> 16;
		r = 32'(x) - q * 32'(NUM_STATES);
		if (r >= 32'(NUM_STATES)) begin
			r = r - 32'(NUM_STATES);
		end
		return ST_W'(r);
	endfunction

	function automatic logic [ACT_W-1:0] action_mod(input logic [2:0] x);
		logic [31:0] q;
		logic [31:0] r;
		q = (32'(x) * 32'(ACT_RECIP)) >> 16;
		r = 32'(x) - q * 32'(NUM_ACTIONS);
		if (r >= 32'(NUM_ACTIONS)) begin
			r = r - 32'(NUM_ACTIONS);
		end
		return ACT_W'(r);
	endfunction

	function automatic logic [ADDR_W-1:0] row_addr(input logic [ST_W-1:0] s,
		input logic [ACT_W-1:0] a);
		return ADDR_W'(s) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(a);
	endfunction

endpackage

@@ hdl/tql_mem.sv @@
// ----------------------------------------------------------------------------
// tql_mem: action value table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tql_mem (
	input  logic                       clk,
	input  tql_pkg::mem_wr_t           wr,
	input  logic [tql_pkg::ADDR_W-1:0] rd_addr,
	output logic [31:0]                rd_data_q
);

	logic [31:0] mem [tql_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

@@ hdl/tql_alu.sv @@
// ----------------------------------------------------------------------------
// tql_alu: shared arithmetic unit
// Saturating add and subtract, and rounded Q16.16 by Q1.16 scaling.
// ----------------------------------------------------------------------------
module tql_alu (
	input  logic               clk,
	input  tql_pkg::alu_req_t  req,
	output logic signed [32:0] res_q
);

	logic signed [49:0] prod;
	logic signed [49:0] rnd;
	logic signed [33:0] sum;
	logic signed [32:0] res_d;

	always_comb begin
		prod = $signed(req.a[31:0]) * $signed({1'b0, req.f});
		rnd  = prod + 50'sd32768;
		sum  = '0;
		unique case (req.op)
			tql_pkg::ALU_ADD: begin
				sum   = {req.a[32], req.a} + {req.b[32], req.b};
				res_d = 33'(tql_pkg::sat32(sum));
			end
			tql_pkg::ALU_SUB: begin
				sum   = {req.a[32], req.a} - {req.b[32], req.b};
				res_d = 33'(tql_pkg::sat32(sum));
			end
			tql_pkg::ALU_MUL: begin
				res_d = rnd[48:16];
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

endmodule

@@ hdl/tabular_q_learning_update.sv @@
// ----------------------------------------------------------------------------
// tabular_q_learning_update: tabular Q-learning step engine
// Keeps a Q16.16 action value table and returns the TD error of each step.
//
//   channel  | signals                                          | dir
//   ---------+--------------------------------------------------+-----
//   input    | in_valid, in_ready, state_index, action_index,   | in
//            | reward, next_state_index, end_of_episode         |
//   output   | out_valid, out_ready, td_err                     | out
//   config   | cfg_we, cfg_index, cfg_data                      | in
//
// A non-terminal item scans the next state's row through the single table
// read port before its update; a terminal item skips the scan.
// After reset the table is swept to zero, one entry a cycle over all
// NUM_STATES * NUM_ACTIONS = 2048 entries, while in_ready stays low.
// One result is held in an output register; the block takes the next item
// while it waits and stalls before write-back if it is still not taken.
// ----------------------------------------------------------------------------
module tabular_q_learning_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         state_index,
	input  logic [2:0]         action_index,
	input  logic signed [31:0] reward,
	input  logic [7:0]         next_state_index,
	input  logic               end_of_episode,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] td_err,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [16:0]        cfg_data
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CUR   = 4'd2;
	localparam logic [3:0] ST_SCAN  = 4'd3;
	localparam logic [3:0] ST_MULD  = 4'd4;
	localparam logic [3:0] ST_TGT   = 4'd5;
	localparam logic [3:0] ST_TD    = 4'd6;
	localparam logic [3:0] ST_MULL  = 4'd7;
	localparam logic [3:0] ST_WB    = 4'd8;
	localparam logic [3:0] ST_WR    = 4'd9;

	localparam int AW = tql_pkg::ADDR_W;
	localparam int BW = tql_pkg::ACT_W;
	localparam logic [BW-1:0] LAST_B   = BW'(tql_pkg::NUM_ACTIONS - 1);
	localparam logic [AW-1:0] LAST_CLR = AW'(tql_pkg::DEPTH - 1);

	logic [3:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      slot_q;
	logic [AW-1:0]      base_q;
	logic [BW-1:0]      b_q;
	logic               terminal_q;
	logic signed [31:0] reward_q;
	logic signed [31:0] cur_q;
	logic signed [31:0] best_q;
	logic signed [31:0] td_q;
	logic signed [31:0] out_td_q;
	logic               out_valid_q;
	logic [16:0]        lr_q;
	logic [16:0]        discount_q;
	logic [16:0]        cfg_clamped;

	logic [AW-1:0]      rd_addr;
	logic [31:0]        rd_data_q;
	logic               out_free;
	logic [AW-1:0]      in_slot;
	logic [AW-1:0]      in_base;

	tql_pkg::mem_wr_t   mem_wr;
	tql_pkg::alu_req_t  alu_req;
	logic signed [32:0] alu_res_q;

	tql_mem u_mem (
		.clk       (clk),
		.wr        (mem_wr),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data_q)
	);

	tql_alu u_alu (
		.clk   (clk),
		.req   (alu_req),
		.res_q (alu_res_q)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign td_err    = out_td_q;
	assign out_free  = !out_valid_q || out_ready;

	assign in_slot = tql_pkg::row_addr(tql_pkg::state_mod(state_index),
		tql_pkg::action_mod(action_index));
	assign in_base = tql_pkg::row_addr(tql_pkg::state_mod(next_state_index), '0);

	assign cfg_clamped = (cfg_data > tql_pkg::ONE_Q16) ? tql_pkg::ONE_Q16 : cfg_data;

	always_comb begin
		rd_addr = base_q;
		unique case (state_q)
			ST_IDLE: rd_addr = in_slot;
			ST_SCAN: rd_addr = (b_q == LAST_B) ? base_q : base_q + AW'(b_q) + AW'(1);
			default: rd_addr = base_q;
		endcase
	end

	always_comb begin
		mem_wr.en   = 1'b0;
		mem_wr.addr = slot_q;
		mem_wr.data = alu_res_q[31:0];
		if (state_q == ST_CLEAR) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = clr_q;
			mem_wr.data = '0;
		end else if (state_q == ST_WR) begin
			mem_wr.en = out_free;
		end
	end

	always_comb begin
		alu_req.op = tql_pkg::ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		alu_req.f  = discount_q;
		unique case (state_q)
			ST_MULD: begin
				alu_req.op = tql_pkg::ALU_MUL;
				alu_req.a  = 33'(best_q);
				alu_req.f  = discount_q;
			end
			ST_TGT: begin
				alu_req.a = 33'(reward_q);
				alu_req.b = alu_res_q;
			end
			ST_TD: begin
				alu_req.op = tql_pkg::ALU_SUB;
				alu_req.a  = terminal_q ? 33'(reward_q) : alu_res_q;
				alu_req.b  = 33'(cur_q);
			end
			ST_MULL: begin
				alu_req.op = tql_pkg::ALU_MUL;
				alu_req.a  = alu_res_q;
				alu_req.f  = lr_q;
			end
			ST_WB: begin
				alu_req.a = 33'(cur_q);
				alu_req.b = alu_res_q;
			end
			ST_WR: begin
				alu_req.a = alu_res_q;
			end
			default: begin
				alu_req.a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q       <= tql_pkg::LR_RESET;
			discount_q <= tql_pkg::DISCOUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tql_pkg::REG_LEARNING_RATE: lr_q       <= cfg_clamped;
				tql_pkg::REG_DISCOUNT:      discount_q <= cfg_clamped;
				default:                    lr_q       <= lr_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WR && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			b_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_CLR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CUR;
					end
				end
				ST_CUR: begin
					b_q     <= '0;
					state_q <= terminal_q ? ST_TD : ST_SCAN;
				end
				ST_SCAN: begin
					if (b_q == LAST_B) begin
						state_q <= ST_MULD;
					end else begin
						b_q <= b_q + BW'(1);
					end
				end
				ST_MULD: state_q <= ST_TGT;
				ST_TGT:  state_q <= ST_TD;
				ST_TD:   state_q <= ST_MULL;
				ST_MULL: state_q <= ST_WB;
				ST_WB:   state_q <= ST_WR;
				ST_WR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			slot_q     <= in_slot;
			base_q     <= in_base;
			terminal_q <= end_of_episode;
			reward_q   <= reward;
		end
		if (state_q == ST_CUR) begin
			cur_q <= rd_data_q;
		end
		if (state_q == ST_SCAN && (b_q == '0 || $signed(rd_data_q) > best_q)) begin
			best_q <= rd_data_q;
		end
		if (state_q == ST_MULL) begin
			td_q <= alu_res_q[31:0];
		end
		if (state_q == ST_WR && out_free) begin
			out_td_q <= td_q;
		end
	end

endmodule

@@ hdl/tql_checker.sv @@
// ----------------------------------------------------------------------------
// tql_checker: port-level checks for the Q-learning engine
// Tracks items in flight, checks that results follow accepts and that the handshakes hold.
// ----------------------------------------------------------------------------
module tql_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] td_err
);

	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(td_err))
		else $error("result dropped or changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready right after an accepted item");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without an accepted item");

	a_ready_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> pending_q <= 2'd1)
		else $error("ready with two items outstanding");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many items in flight");

endmodule

bind tabular_q_learning_update tql_checker u_tql_checker (.*);
